// ===== hw/rtl/nrt_pkg.sv =====
// Shared types and constants for the network route table.
// Used by nrt_engine and network_route_table; depends on nothing else.

package nrt_pkg;

   // Default sizing of the table.
   localparam int DefNumPorts   = 4;
   localparam int DefTableDepth = 64;
   localparam int DefMacBytes   = 7;

   // Fixed field widths.
   localparam int MaxPorts = 4;
   localparam int PortW    = 2;
   localparam int NetW     = 16;
   localparam int MacW     = 56;
   localparam int MacLenW  = 3;

   // Network numbers that a lookup rejects.
   localparam logic [NetW-1:0] NetNone      = 16'h0000;
   localparam logic [NetW-1:0] NetBroadcast = 16'hFFFF;

   // Request operations.
   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   // Response status codes.
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_MISS    = 3'd1,
      ST_ILLEGAL = 3'd2,
      ST_FULL    = 3'd3,
      ST_DUP     = 3'd4
   } status_type;

   // Engine sequencer states.
   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   // Request beat; the last field sits in the lowest bits.
   typedef struct packed {
      logic [MacLenW-1:0] next_hop_mac_len;
      logic [MacW-1:0]    next_hop_mac;
      logic [PortW-1:0]   port_index;
      logic [NetW-1:0]    network;
      op_type             operation;
   } req_item_type;

   // Response beat; the last field sits in the lowest bits.
   typedef struct packed {
      logic [MacLenW-1:0] found_mac_len;
      logic [MacW-1:0]    found_mac;
      logic               directly_attached;
      logic [PortW-1:0]   found_port;
      status_type         status;
   } rsp_item_type;

   localparam int ReqItemW = $bits(req_item_type);
   localparam int RspItemW = $bits(rsp_item_type);
   localparam int ReqDataW = ((ReqItemW + 7) / 8) * 8;
   localparam int RspDataW = ((RspItemW + 7) / 8) * 8;

endpackage

// ===== hw/rtl/nrt_engine.sv =====
// Route table engine: entry memory, clearing pass, per-request scan and writeback.
// Depends on nrt_pkg; instantiated by network_route_table.

module nrt_engine import nrt_pkg::*; #(
   parameter int NUM_PORTS   = DefNumPorts,
   parameter int TABLE_DEPTH = DefTableDepth,
   parameter int MAC_BYTES   = DefMacBytes
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  req_item_type                     req_item,
   input  logic [MaxPorts-1:0][NetW-1:0]    port_net,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rsp_item_type                     rsp_item
);

   localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CntW  = AddrW + 1;
   localparam logic [CntW-1:0]    DepthCnt = CntW'(TABLE_DEPTH);
   localparam logic [CntW-1:0]    LastCnt  = CntW'(TABLE_DEPTH - 1);
   localparam logic [PortW:0]     NumPortsCnt = (PortW + 1)'(NUM_PORTS);
   localparam logic [MacLenW:0]   MacBytesCnt = (MacLenW + 1)'(MAC_BYTES);

   typedef struct packed {
      logic               valid;
      logic [NetW-1:0]    network;
      logic [PortW-1:0]   port;
      logic [MacW-1:0]    mac;
      logic [MacLenW-1:0] mac_len;
   } entry_type;

   // Entry storage, one synchronous read and one write port.
   entry_type mem [TABLE_DEPTH];

   state_type          state_ff, state_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   req_item_type       item_ff, item_in;
   logic               port_ok_ff, port_ok_in;

   logic               rd_live_ff, rd_live_in;
   logic [AddrW-1:0]   rd_idx_ff, rd_idx_in;
   logic [AddrW-1:0]   rd_addr;
   entry_type          rd_data_ff;

   logic               wr_en;
   logic [AddrW-1:0]   wr_addr;
   entry_type          wr_data;

   logic               match_found_ff, match_found_in;
   logic [AddrW-1:0]   match_idx_ff, match_idx_in;
   logic               free_found_ff, free_found_in;
   logic [AddrW-1:0]   free_idx_ff, free_idx_in;
   logic               best_valid_ff, best_valid_in;
   logic [PortW-1:0]   best_port_ff, best_port_in;
   logic [MacW-1:0]    best_mac_ff, best_mac_in;
   logic [MacLenW-1:0] best_len_ff, best_len_in;

   logic               net_hit;
   logic               cfg_hit;
   logic [PortW-1:0]   cfg_port;
   logic [MacLenW-1:0] len_sat;

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         cnt_ff         <= '0;
         rd_live_ff     <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         best_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         rd_live_ff     <= rd_live_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         best_valid_ff  <= best_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      port_ok_ff   <= port_ok_in;
      rd_idx_ff    <= rd_idx_in;
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      best_port_ff <= best_port_in;
      best_mac_ff  <= best_mac_in;
      best_len_ff  <= best_len_in;
   end

   // The entry just read names the requested network.
   assign net_hit = rd_live_ff && rd_data_ff.valid &&
                    (rd_data_ff.network == item_ff.network);

   // Lowest enabled port whose configured network matches.
   always_comb begin
      cfg_hit  = 1'b0;
      cfg_port = '0;
      for (int p = 0; p < MaxPorts; p++) begin
         if ((p < NUM_PORTS) && !cfg_hit && (port_net[p] == item_ff.network)) begin
            cfg_hit  = 1'b1;
            cfg_port = PortW'(p);
         end
      end
   end

   // Stored MAC length is capped at the MAC size.
   assign len_sat = ({1'b0, item_ff.next_hop_mac_len} > MacBytesCnt) ?
                    MacLenW'(MAC_BYTES) : item_ff.next_hop_mac_len;

   // Sequencer: next state, scan tracking, writeback and response.
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      item_in        = item_ff;
      port_ok_in     = port_ok_ff;
      rd_live_in     = 1'b0;
      rd_idx_in      = cnt_ff[AddrW-1:0];
      rd_addr        = cnt_ff[AddrW-1:0];
      wr_en          = 1'b0;
      wr_addr        = cnt_ff[AddrW-1:0];
      wr_data        = '0;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      best_valid_in  = best_valid_ff;
      best_port_in   = best_port_ff;
      best_mac_in    = best_mac_ff;
      best_len_in    = best_len_ff;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      rsp_item       = '0;
      rsp_item.status = ST_MISS;

      unique case (state_ff)
         S_CLEAR: begin
            // Mark every entry invalid, one per cycle.
            wr_en = 1'b1;
            if (cnt_ff == LastCnt) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in        = req_item;
               port_ok_in     = ({1'b0, req_item.port_index} < NumPortsCnt);
               cnt_in         = '0;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               best_valid_in  = 1'b0;
               state_in       = S_SCAN;
            end
         end

         S_SCAN: begin
            // Issue the next read while checking the entry read last cycle.
            if (cnt_ff < DepthCnt) begin
               rd_live_in = 1'b1;
               cnt_in     = cnt_ff + 1'b1;
            end else begin
               state_in = S_FINISH;
            end
            if (net_hit && (rd_data_ff.port == item_ff.port_index) && !match_found_ff) begin
               match_found_in = 1'b1;
               match_idx_in   = rd_idx_ff;
            end
            if (rd_live_ff && !rd_data_ff.valid && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = rd_idx_ff;
            end
            if (net_hit && (!best_valid_ff || (rd_data_ff.port < best_port_ff))) begin
               best_valid_in = 1'b1;
               best_port_in  = rd_data_ff.port;
               best_mac_in   = rd_data_ff.mac;
               best_len_in   = rd_data_ff.mac_len;
            end
         end

         S_FINISH: begin
            rsp_valid = 1'b1;
            case (item_ff.operation)
               OP_ADD: begin
                  wr_addr         = free_idx_ff;
                  wr_data.valid   = 1'b1;
                  wr_data.network = item_ff.network;
                  wr_data.port    = item_ff.port_index;
                  wr_data.mac     = item_ff.next_hop_mac;
                  wr_data.mac_len = len_sat;
                  if (!port_ok_ff) begin
                     rsp_item.status = ST_MISS;
                  end else if (match_found_ff) begin
                     rsp_item.status = ST_DUP;
                  end else if (free_found_ff) begin
                     rsp_item.status = ST_OK;
                     wr_en           = rsp_ready;
                  end else begin
                     rsp_item.status = ST_FULL;
                  end
               end
               OP_REMOVE: begin
                  wr_addr = match_idx_ff;
                  if (port_ok_ff && match_found_ff) begin
                     rsp_item.status = ST_OK;
                     wr_en           = rsp_ready;
                  end
               end
               OP_LOOKUP: begin
                  if ((item_ff.network == NetNone) || (item_ff.network == NetBroadcast)) begin
                     rsp_item.status = ST_ILLEGAL;
                  end else if (best_valid_ff && (!cfg_hit || (best_port_ff < cfg_port))) begin
                     rsp_item.status        = ST_OK;
                     rsp_item.found_port    = best_port_ff;
                     rsp_item.found_mac     = best_mac_ff;
                     rsp_item.found_mac_len = best_len_ff;
                  end else if (cfg_hit) begin
                     rsp_item.status            = ST_OK;
                     rsp_item.found_port        = cfg_port;
                     rsp_item.directly_attached = 1'b1;
                  end
               end
               default: begin
                  rsp_item.status = ST_MISS;
               end
            endcase
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/network_route_table.sv =====
// Network route table: maps a network number to a port and next-hop MAC.
// Usage:
//  - req channel (req_tvalid/req_tready/req_tdata) carries one add, remove or
//    lookup per beat; rsp channel returns exactly one status beat per request.
//  - csr port writes the network attached to each port (index 0 to 3) on any
//    cycle with csr_wr_en high; write only while no request is in flight.
//  - Each request scans the whole entry memory through its single read port:
//    the response is registered once the scan is done, and a new request is
//    taken only after the engine has handed the previous response onward.
//  - After reset the engine clears every entry of the entry memory;
//    req_tready stays low until that pass is done. The csr registers
//    reset to zero, which means no attached network.
//  - The response sits in an output register. While rsp_tready is low the next
//    request is still accepted and scanned; it waits at the end of its scan
//    until the output register frees up.
// Depends on nrt_pkg and nrt_engine.

module network_route_table import nrt_pkg::*; #(
   parameter int NUM_PORTS   = DefNumPorts,
   parameter int TABLE_DEPTH = DefTableDepth,
   parameter int MAC_BYTES   = DefMacBytes
) (
   input  logic                clock,
   input  logic                reset,
   // Request channel.
   input  logic                req_tvalid,
   output logic                req_tready,
   // operation[1:0], network[17:2], port_index[19:18], next_hop_mac[75:20],
   // next_hop_mac_len[78:76], zero pad above
   input  logic [ReqDataW-1:0] req_tdata,
   // Response channel.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // status[2:0], found_port[4:3], directly_attached[5], found_mac[61:6],
   // found_mac_len[64:62], zero pad above
   output logic [RspDataW-1:0] rsp_tdata,
   // Configuration port.
   input  logic                csr_wr_en,
   input  logic [PortW-1:0]    csr_index,
   input  logic [NetW-1:0]     csr_wdata
);

   logic [MaxPorts-1:0][NetW-1:0] port_net_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_item_type                  rsp_item_ff, rsp_item_in;
   req_item_type                  req_item;
   rsp_item_type                  eng_item;
   logic                          eng_valid;
   logic                          eng_ready;

   // Attached network registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         port_net_ff <= '0;
      end else if (csr_wr_en) begin
         port_net_ff[csr_index] <= csr_wdata;
      end
   end

   assign req_item = req_item_type'(req_tdata[ReqItemW-1:0]);

   nrt_engine #(
      .NUM_PORTS   (NUM_PORTS),
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAC_BYTES   (MAC_BYTES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (req_item),
      .port_net  (port_net_ff),
      .rsp_valid (eng_valid),
      .rsp_ready (eng_ready),
      .rsp_item  (eng_item)
   );

   // Output register: free when empty or when its beat is taken this cycle.
   assign eng_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (eng_ready) begin
         rsp_valid_in = eng_valid;
         if (eng_valid) begin
            rsp_item_in = eng_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataW - RspItemW){1'b0}}, rsp_item_ff};

endmodule

// ===== sim/tb_network_route_table.sv =====
// Self-checking testbench for network_route_table: directed route cases, a table fill and
// random add, remove and lookup traffic under four handshake pressure phases.
// Depends on nrt_pkg and the network_route_table RTL; reads no files.

module tb_network_route_table import nrt_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumPorts     = DefNumPorts;
   localparam int TableDepth   = DefTableDepth;
   localparam int MacBytes     = DefMacBytes;
   localparam int RandPerPhase = 465;

   // Clock, reset and block ports.
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_wr_en = 1'b0;
   logic [PortW-1:0]    csr_index = '0;
   logic [NetW-1:0]     csr_wdata = '0;

   // Mirror of the route table and the attached networks.
   logic               lrn_valid [TableDepth];
   logic [NetW-1:0]    lrn_net   [TableDepth];
   logic [PortW-1:0]   lrn_port  [TableDepth];
   logic [MacW-1:0]    lrn_mac   [TableDepth];
   logic [MacLenW-1:0] lrn_len   [TableDepth];
   logic [NetW-1:0]    attached_net [MaxPorts];

   // Answers predicted for accepted requests, oldest first.
   rsp_item_type answers_due [$];

   // Port networks last programmed, used to aim the random traffic.
   logic [NetW-1:0] cfg_now [MaxPorts];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;
   int status_seen [5] = '{default: 0};

   network_route_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Random backpressure on the response channel.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Slot of the learned route for this network on this port, or -1.
   function automatic int learned_slot(logic [NetW-1:0] netw, logic [PortW-1:0] port);
      for (int i = 0; i < TableDepth; i++) begin
         if (lrn_valid[i] && lrn_net[i] == netw && lrn_port[i] == port) return i;
      end
      return -1;
   endfunction

   // Applies one request to the mirror and returns the answer the block must give.
   function automatic rsp_item_type route_answer(req_item_type rq);
      rsp_item_type ans;
      int slot;
      ans = '0;
      ans.status = ST_MISS;
      case (rq.operation)
         OP_ADD: begin
            if (int'(rq.port_index) < NumPorts) begin
               if (learned_slot(rq.network, rq.port_index) >= 0) begin
                  ans.status = ST_DUP;
               end else begin
                  // Lowest free slot takes the route; none left means full.
                  ans.status = ST_FULL;
                  for (int i = 0; i < TableDepth; i++) begin
                     if (!lrn_valid[i]) begin
                        lrn_valid[i] = 1'b1;
                        lrn_net[i]   = rq.network;
                        lrn_port[i]  = rq.port_index;
                        lrn_mac[i]   = rq.next_hop_mac;
                        lrn_len[i]   = (rq.next_hop_mac_len > MacBytes) ?
                                       MacLenW'(MacBytes) : rq.next_hop_mac_len;
                        ans.status   = ST_OK;
                        break;
                     end
                  end
               end
            end
         end
         OP_REMOVE: begin
            if (int'(rq.port_index) < NumPorts) begin
               slot = learned_slot(rq.network, rq.port_index);
               if (slot >= 0) begin
                  lrn_valid[slot] = 1'b0;
                  ans.status = ST_OK;
               end
            end
         end
         OP_LOOKUP: begin
            if (rq.network == NetNone || rq.network == NetBroadcast) begin
               ans.status = ST_ILLEGAL;
            end else begin
               // Lowest port wins; within a port the attached network comes first.
               for (int p = 0; p < NumPorts; p++) begin
                  if (attached_net[p] == rq.network) begin
                     ans.status            = ST_OK;
                     ans.found_port        = PortW'(p);
                     ans.directly_attached = 1'b1;
                     break;
                  end
                  slot = learned_slot(rq.network, PortW'(p));
                  if (slot >= 0) begin
                     ans.status        = ST_OK;
                     ans.found_port    = PortW'(p);
                     ans.found_mac     = lrn_mac[slot];
                     ans.found_mac_len = lrn_len[slot];
                     break;
                  end
               end
            end
         end
         default: begin
            ans.status = ST_MISS;
         end
      endcase
      return ans;
   endfunction

   function automatic void check_field(string field, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected 'h%0h, actual 'h%0h", field, want, got);
         error_count++;
      end
   endfunction

   // Tracks csr writes and request beats, and checks every response beat.
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         lrn_valid    = '{default: 1'b0};
         attached_net = '{default: '0};
      end else begin
         if (csr_wr_en) attached_net[csr_index] = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RspItemW-1:0];
            if (answers_due.size() == 0) begin
               $error("response beat with no request outstanding");
               error_count++;
            end else begin
               want = answers_due.pop_front();
               check_field("status", want.status, got.status);
               check_field("found_port", want.found_port, got.found_port);
               check_field("directly_attached", want.directly_attached,
                           got.directly_attached);
               check_field("found_mac", want.found_mac, got.found_mac);
               check_field("found_mac_len", want.found_mac_len, got.found_mac_len);
               status_seen[int'(want.status)]++;
            end
         end
         if (req_tvalid && req_tready) begin
            answers_due.push_back(route_answer(req_item_type'(req_tdata[ReqItemW-1:0])));
         end
      end
   end

   function automatic req_item_type make_request(op_type op, logic [NetW-1:0] netw,
                                                 logic [PortW-1:0] port,
                                                 logic [MacW-1:0] mac,
                                                 logic [MacLenW-1:0] mac_len);
      req_item_type rq;
      rq.operation        = op;
      rq.network          = netw;
      rq.port_index       = port;
      rq.next_hop_mac     = mac;
      rq.next_hop_mac_len = mac_len;
      return rq;
   endfunction

   function automatic logic [MacW-1:0] rand_mac();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return '1;
      if (pick == 1) return '0;
      return MacW'({$urandom(), $urandom()});
   endfunction

   // Sends one request beat; tvalid stays high afterwards for a following beat.
   task automatic send_request(input req_item_type item);
      logic [ReqDataW-1:0] beat;
      beat = '0;
      beat[ReqItemW-1:0] = item;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops sending and waits until every outstanding answer has come back.
   task automatic wait_all_answered();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_port_networks(input logic [NetW-1:0] n0, n1, n2, n3);
      logic [NetW-1:0] vals [MaxPorts];
      vals = '{n0, n1, n2, n3};
      for (int k = 0; k < MaxPorts; k++) begin
         cfg_now[k] = vals[k];
         csr_wr_en <= 1'b1;
         csr_index <= PortW'(k);
         csr_wdata <= vals[k];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   // Reserved network numbers are rejected by lookup, even when attached.
   task automatic test_illegal_lookups();
      send_request(make_request(OP_LOOKUP, NetNone, 2'd0, '0, 3'd0));
      send_request(make_request(OP_LOOKUP, NetBroadcast, 2'd3, '1, 3'd7));
      send_request(make_request(OP_LOOKUP, 16'h0BAD, 2'd1, '0, 3'd0));
      wait_all_answered();
   endtask

   // Attached networks hit without a MAC and shadow learned routes for the same number.
   task automatic test_attached_networks();
      send_request(make_request(OP_LOOKUP, 16'h0001, 2'd0, '0, 3'd0));
      send_request(make_request(OP_LOOKUP, 16'h1234, 2'd0, '0, 3'd0));
      send_request(make_request(OP_ADD, 16'h1234, 2'd2, '1, 3'd7));
      send_request(make_request(OP_LOOKUP, 16'h1234, 2'd0, '0, 3'd0));
      send_request(make_request(OP_ADD, 16'h0001, 2'd3, 56'h0102030405, 3'd5));
      send_request(make_request(OP_LOOKUP, 16'h0001, 2'd3, '0, 3'd0));
      wait_all_answered();
   endtask

   // Learned adds, a duplicate on the same port, and the lowest port winning a lookup.
   task automatic test_add_and_duplicate();
      send_request(make_request(OP_ADD, 16'h0500, 2'd3, '1, 3'd7));
      send_request(make_request(OP_ADD, 16'h0500, 2'd3, 56'h1, 3'd1));
      send_request(make_request(OP_ADD, 16'h0500, 2'd0, '0, 3'd0));
      send_request(make_request(OP_LOOKUP, 16'h0500, 2'd2, '1, 3'd7));
      send_request(make_request(OP_ADD, NetNone, 2'd0, 56'hAA55, 3'd2));
      send_request(make_request(OP_ADD, NetBroadcast, 2'd3, 56'h55AA, 3'd2));
      send_request(make_request(OP_ADD, 16'hFFFE, 2'd1, rand_mac(), 3'd3));
      send_request(make_request(OP_LOOKUP, 16'hFFFE, 2'd0, '0, 3'd0));
      wait_all_answered();
   endtask

   // Removal uncovers the next port's route; a second removal misses.
   task automatic test_remove_paths();
      send_request(make_request(OP_REMOVE, 16'h0500, 2'd0, '0, 3'd0));
      send_request(make_request(OP_LOOKUP, 16'h0500, 2'd0, '0, 3'd0));
      send_request(make_request(OP_REMOVE, 16'h0500, 2'd0, '0, 3'd0));
      send_request(make_request(OP_REMOVE, NetNone, 2'd0, '0, 3'd0));
      send_request(make_request(OP_REMOVE, NetBroadcast, 2'd3, '1, 3'd7));
      wait_all_answered();
   endtask

   task automatic test_unused_operation();
      send_request(make_request(OP_UNUSED, 16'h1234, 2'd2, '1, 3'd7));
      wait_all_answered();
   endtask

   // Fills every free slot, overflows, then frees one slot and reuses it.
   task automatic test_table_full();
      int free_slots;
      free_slots = 0;
      for (int i = 0; i < TableDepth; i++) begin
         if (!lrn_valid[i]) free_slots++;
      end
      for (int k = 0; k < free_slots + 3; k++) begin
         send_request(make_request(OP_ADD, 16'h4000 + NetW'(k), PortW'(k % 4), rand_mac(),
                                   MacLenW'($urandom_range(7))));
      end
      send_request(make_request(OP_LOOKUP, 16'h4001, 2'd0, '0, 3'd0));
      send_request(make_request(OP_REMOVE, 16'h4005, 2'd0, '0, 3'd0));
      send_request(make_request(OP_REMOVE, 16'h4005, 2'd1, '0, 3'd0));
      send_request(make_request(OP_ADD, 16'h7777, 2'd0, rand_mac(), 3'd6));
      send_request(make_request(OP_ADD, 16'h7778, 2'd0, rand_mac(), 3'd6));
      send_request(make_request(OP_LOOKUP, 16'h7777, 2'd0, '0, 3'd0));
      wait_all_answered();
   endtask

   // Random traffic over a small set of networks so that adds, removes and lookups meet.
   task automatic test_random_traffic(input int beats, input int add_pct);
      logic [NetW-1:0] netw_set [24];
      req_item_type rq;
      int pick;
      int slot;
      int remove_pct;
      for (int k = 0; k < MaxPorts; k++) netw_set[k] = cfg_now[k];
      netw_set[4] = NetNone;
      netw_set[5] = NetBroadcast;
      netw_set[6] = 16'h0001;
      netw_set[7] = 16'hFFFE;
      for (int k = 8; k < 16; k++) netw_set[k] = 16'h4000 + NetW'($urandom_range(70));
      for (int k = 16; k < 24; k++) netw_set[k] = NetW'($urandom());
      remove_pct = (add_pct >= 50) ? 15 : 30;
      repeat (beats) begin
         pick = $urandom_range(99);
         if (pick < add_pct) rq.operation = OP_ADD;
         else if (pick < add_pct + remove_pct) rq.operation = OP_REMOVE;
         else if (pick < 97) rq.operation = OP_LOOKUP;
         else rq.operation = OP_UNUSED;
         rq.network = ($urandom_range(3) == 0) ? NetW'($urandom()) :
                                                 netw_set[$urandom_range(23)];
         rq.port_index       = PortW'($urandom_range(3));
         rq.next_hop_mac     = rand_mac();
         rq.next_hop_mac_len = MacLenW'($urandom_range(7));
         // For half the removes and lookups, pick a random slot and aim at its route if it is stored.
         if (rq.operation inside {OP_REMOVE, OP_LOOKUP} && $urandom_range(1) == 1) begin
            slot = $urandom_range(TableDepth - 1);
            if (lrn_valid[slot]) begin
               rq.network    = lrn_net[slot];
               rq.port_index = lrn_port[slot];
            end
         end
         send_request(rq);
      end
      wait_all_answered();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      set_port_networks(16'h0001, NetBroadcast, 16'h1234, NetNone);
      test_illegal_lookups();
      test_attached_networks();
      test_add_and_duplicate();
      test_remove_paths();
      test_unused_operation();
      test_table_full();

      // No idling, random attached networks, table draining.
      set_port_networks(NetW'($urandom_range(1, 65534)), NetW'($urandom_range(1, 65534)),
                        NetW'($urandom_range(1, 65534)), NetW'($urandom_range(1, 65534)));
      test_random_traffic(RandPerPhase, 30);

      // Sender idles often, no attached networks, table filling.
      send_idle_pct = 56;
      set_port_networks(NetNone, NetNone, NetNone, NetNone);
      test_random_traffic(RandPerPhase, 55);

      // Receiver stalls often, two ports share a network.
      send_idle_pct  = 0;
      recv_stall_pct = 56;
      set_port_networks(16'hFFFE, 16'hFFFE, 16'h0001, 16'h4005);
      test_random_traffic(RandPerPhase, 30);

      // Light idling on both sides, attached networks over the full range.
      send_idle_pct  = 11;
      recv_stall_pct = 11;
      set_port_networks(NetW'($urandom()), NetW'($urandom()), NetW'($urandom()),
                        NetBroadcast);
      test_random_traffic(RandPerPhase, 55);

      // Give the block one more scan time to show any stray beat.
      repeat (TableDepth + 8) @(posedge clock);
      $display("Checked %0d answers: ok %0d, miss %0d, illegal %0d, full %0d, duplicate %0d.",
               status_seen.sum(), status_seen[ST_OK], status_seen[ST_MISS],
               status_seen[ST_ILLEGAL], status_seen[ST_FULL], status_seen[ST_DUP]);
      $display("Traffic ran under five port network settings and four idle patterns.");
      if (error_count == 0) begin
         $display("PASS network_route_table");
      end else begin
         $display("FAIL network_route_table");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #20ms;
      $display("FAIL network_route_table");
      $finish;
   end

endmodule
